// File: rtl/tms_pkg.sv
// Package for the Turing machine stepper: sizes, command codes, rule layout
// and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  localparam int TAPE_DEPTH = 1024;
  localparam int RULE_DEPTH = 128;
  localparam int STATE_BITS = 8;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int RULE_AW = $clog2(RULE_DEPTH);
  localparam int SCAN_W  = $clog2(RULE_DEPTH + 2);

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_STEP    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;

  localparam logic [1:0] RUN_ACTIVE   = 2'd0;
  localparam logic [1:0] RUN_HALTED   = 2'd1;
  localparam logic [1:0] RUN_NO_RULE  = 2'd2;
  localparam logic [1:0] RUN_OFF_TAPE = 2'd3;

  localparam logic [1:0] CFG_HALT_CODE  = 2'd0;
  localparam logic [1:0] CFG_START_CODE = 2'd1;
  localparam logic [1:0] CFG_RULE_COUNT = 2'd2;

  localparam logic [7:0] BLANK_SYMBOL = 8'd95;
  localparam logic [7:0] HALT_RESET   = 8'd255;
  localparam logic [7:0] START_RESET  = 8'd0;
  localparam logic [7:0] COUNT_RESET  = 8'd0;

  typedef struct packed {
    logic [STATE_BITS-1:0] m_state;
    logic [7:0]            m_sym;
    logic [7:0]            w_sym;
    logic [1:0]            move;
    logic [STATE_BITS-1:0] next;
  } rule_t;

  typedef struct packed {
    logic clr_wr;
    logic latch;
    logic rule_wr;
    logic cell_wr;
    logic restart;
    logic set_halted;
    logic scan_start;
    logic sym_load;
    logic scan_next;
    logic apply;
    logic set_no_rule;
    logic read_addr;
  } tms_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       stopped;
    logic       at_halt;
    logic       clr_last;
    logic       scan_end;
    logic       match;
  } tms_stat_t;

endpackage

`default_nettype wire

// File: rtl/tms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tms_datapath.sv
// Datapath of the Turing machine stepper: configuration registers, machine
// registers, item latch, scan counter, tape and rule memories.
// Depends on tms_pkg and tms_ram.
`timescale 1ns / 1ps
`default_nettype none

module tms_datapath
  import tms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tms_cmd_t   cmd_i,
  output tms_stat_t       stat_o,
  input  wire logic       cfg_valid_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [6:0] rule_index_i,
  input  wire logic [7:0] match_state_i,
  input  wire logic [7:0] match_symbol_i,
  input  wire logic [7:0] write_symbol_i,
  input  wire logic [1:0] head_move_i,
  input  wire logic [7:0] goto_state_i,
  input  wire logic [9:0] cell_address_i,
  input  wire logic [7:0] cell_symbol_i,
  output logic      [7:0] machine_state_o,
  output logic      [9:0] head_position_o,
  output logic      [7:0] read_symbol_o,
  output logic      [1:0] run_status_o
);

  logic [7:0] halt_code_q, start_code_q, rule_count_q;
  logic [STATE_BITS-1:0] cur_q, cur_d;
  logic [TAPE_AW-1:0]    head_q, head_d;
  logic [1:0]            status_q, status_d;
  logic [TAPE_AW-1:0]    clr_cnt_q;
  logic [SCAN_W-1:0]     scan_cnt_q;
  logic [2:0]            op_q;
  logic [6:0]            rule_idx_q;
  rule_t                 rule_in_q;
  logic [9:0]            cell_addr_q;
  logic [7:0]            cell_sym_q;
  logic [7:0]            sym_q;

  rule_t                 rule_rd;
  logic [7:0]            tape_rd;
  logic [STATE_BITS-1:0] halt_state;
  logic [SCAN_W-1:0]     limit;
  logic [TAPE_AW:0]      head_up;
  logic                  off_tape;
  logic [TAPE_AW-1:0]    moved_head;
  logic                  cell_in_range;
  logic                  idx_in_range;
  logic [TAPE_AW-1:0]    cell_addr;
  logic                  tape_we;
  logic [TAPE_AW-1:0]    tape_waddr;
  logic [TAPE_AW-1:0]    tape_raddr;
  logic [7:0]            tape_wdata;

  assign halt_state    = STATE_BITS'(halt_code_q);
  assign cell_in_range = 32'(cell_addr_q) < TAPE_DEPTH;
  assign idx_in_range  = 32'(rule_idx_q) < RULE_DEPTH;
  assign cell_addr     = TAPE_AW'(cell_addr_q);

  always_comb begin
    if (32'(rule_count_q) >= RULE_DEPTH) begin
      limit = SCAN_W'(RULE_DEPTH);
    end else begin
      limit = SCAN_W'(rule_count_q);
    end
  end

  always_comb begin
    head_up    = {1'b0, head_q} + (TAPE_AW + 1)'(1);
    off_tape   = 1'b0;
    moved_head = head_q;
    if (rule_rd.move == MOVE_RIGHT) begin
      off_tape   = head_up >= (TAPE_AW + 1)'(TAPE_DEPTH);
      moved_head = head_up[TAPE_AW-1:0];
    end else if (rule_rd.move == MOVE_LEFT) begin
      off_tape   = head_q == '0;
      moved_head = head_q - TAPE_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_code_q  <= HALT_RESET;
      start_code_q <= START_RESET;
      rule_count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HALT_CODE:  halt_code_q  <= cfg_data_i;
        CFG_START_CODE: start_code_q <= cfg_data_i;
        CFG_RULE_COUNT: rule_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_d    = cur_q;
    head_d   = head_q;
    status_d = status_q;
    if (cmd_i.restart) begin
      cur_d    = STATE_BITS'(start_code_q);
      head_d   = TAPE_AW'(1);
      status_d = RUN_ACTIVE;
    end
    if (cmd_i.set_halted) begin
      status_d = RUN_HALTED;
    end
    if (cmd_i.set_no_rule) begin
      status_d = RUN_NO_RULE;
    end
    if (cmd_i.apply) begin
      if (off_tape) begin
        status_d = RUN_OFF_TAPE;
      end else begin
        head_d = moved_head;
        cur_d  = rule_rd.next;
        if (rule_rd.next == halt_state) begin
          status_d = RUN_HALTED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= STATE_BITS'(START_RESET);
      head_q     <= TAPE_AW'(1);
      status_q   <= RUN_ACTIVE;
      clr_cnt_q  <= '0;
      scan_cnt_q <= '0;
      op_q       <= OP_LOAD;
    end else begin
      cur_q    <= cur_d;
      head_q   <= head_d;
      status_q <= status_d;
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + TAPE_AW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_next) begin
        scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
      end
      if (cmd_i.latch) begin
        op_q <= opcode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rule_idx_q        <= rule_index_i;
      rule_in_q.m_state <= STATE_BITS'(match_state_i);
      rule_in_q.m_sym   <= match_symbol_i;
      rule_in_q.w_sym   <= write_symbol_i;
      rule_in_q.move    <= head_move_i;
      rule_in_q.next    <= STATE_BITS'(goto_state_i);
      cell_addr_q       <= cell_address_i;
      cell_sym_q        <= cell_symbol_i;
    end
    if (cmd_i.sym_load) begin
      sym_q <= tape_rd;
    end
  end

  always_comb begin
    tape_we    = cmd_i.clr_wr || (cmd_i.cell_wr && cell_in_range) || (cmd_i.apply && !off_tape);
    tape_waddr = head_q;
    tape_wdata = rule_rd.w_sym;
    if (cmd_i.clr_wr) begin
      tape_waddr = clr_cnt_q;
      tape_wdata = BLANK_SYMBOL;
    end else if (cmd_i.cell_wr) begin
      tape_waddr = cell_addr;
      tape_wdata = cell_sym_q;
    end
    tape_raddr = cmd_i.read_addr ? cell_addr : head_q;
  end

  tms_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_DEPTH)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rd)
  );

  tms_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_DEPTH)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rule_wr && idx_in_range),
    .waddr_i (RULE_AW'(rule_idx_q)),
    .wdata_i (rule_in_q),
    .raddr_i (scan_cnt_q[RULE_AW-1:0]),
    .rdata_o (rule_rd)
  );

  assign stat_o.op       = op_q;
  assign stat_o.stopped  = status_q != RUN_ACTIVE;
  assign stat_o.at_halt  = cur_q == halt_state;
  assign stat_o.clr_last = clr_cnt_q == TAPE_AW'(TAPE_DEPTH - 1);
  assign stat_o.scan_end = scan_cnt_q > limit;
  assign stat_o.match    = (rule_rd.m_state == cur_q) && (rule_rd.m_sym == sym_q);

  assign machine_state_o = 8'(cur_q);
  assign head_position_o = 10'(head_q);
  assign read_symbol_o   = (op_q == OP_READ && !cell_in_range) ? 8'd0 : tape_rd;
  assign run_status_o    = status_q;

endmodule

`default_nettype wire

// File: rtl/tms_ctrl.sv
// Controller of the Turing machine stepper: sequences the tape clear after
// reset, each item's operation, the rule scan and the result strobe.
// Depends on tms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tms_ctrl
  import tms_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output logic           done_o,
  input  wire tms_stat_t stat_i,
  output tms_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_SYM   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_READ;
        unique case (stat_i.op)
          OP_LOAD:    cmd_o.rule_wr = 1'b1;
          OP_WRITE:   cmd_o.cell_wr = 1'b1;
          OP_RESTART: cmd_o.restart = 1'b1;
          OP_STEP: begin
            if (!stat_i.stopped) begin
              if (stat_i.at_halt) begin
                cmd_o.set_halted = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SYM;
              end
            end
          end
          default: ;
        endcase
      end
      S_SYM: begin
        cmd_o.sym_load  = 1'b1;
        cmd_o.scan_next = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          cmd_o.set_no_rule = 1'b1;
          state_d           = S_READ;
        end else if (stat_i.match) begin
          cmd_o.apply = 1'b1;
          state_d     = S_READ;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.read_addr = stat_i.op == OP_READ;
        state_d         = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_OUT;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state is not one-hot");

  a_out_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> $past(state_q) == S_READ)
    else $error("result strobe without a preceding tape read");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> state_q == S_EXEC)
    else $error("accepted item did not start execution");

  a_single_tape_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.clr_wr && (cmd_o.cell_wr || cmd_o.apply)))
    else $error("tape clear overlaps another tape write");

endmodule

`default_nettype wire

// File: rtl/turing_machine_stepper_core.sv
// Top level of the Turing machine stepper: controller plus datapath.
// Depends on tms_pkg, tms_ctrl and tms_datapath.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// The opcode selects load rule, write tape cell, step, read tape cell or
// restart. Each item gives one result, shown on the result ports for one
// cycle while done_o is high; the receiver cannot stall it.
// A step that runs the rule search examines the rules in index order and
// applies the first one that matches; it searches at most the rule count,
// capped at 128, and none may match. The search reads one rule per cycle
// from the rule memory. Another item is accepted the cycle after done_o.
// Configuration registers are written through cfg_valid_i with
// cfg_index_i and cfg_data_i; cfg_ready_o is always high.
// After reset the tape memory is cleared to blank, one cell per cycle, over
// all 1024 cells; busy stays high during this pass.
`timescale 1ns / 1ps
`default_nettype none

module turing_machine_stepper_core
  import tms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  output logic            done_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [6:0] rule_index_i,
  input  wire logic [7:0] match_state_i,
  input  wire logic [7:0] match_symbol_i,
  input  wire logic [7:0] write_symbol_i,
  input  wire logic [1:0] head_move_i,
  input  wire logic [7:0] goto_state_i,
  input  wire logic [9:0] cell_address_i,
  input  wire logic [7:0] cell_symbol_i,
  output logic      [7:0] machine_state_o,
  output logic      [9:0] head_position_o,
  output logic      [7:0] read_symbol_o,
  output logic      [1:0] run_status_o
);

  tms_cmd_t  cmd;
  tms_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tms_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .rule_index_i    (rule_index_i),
    .match_state_i   (match_state_i),
    .match_symbol_i  (match_symbol_i),
    .write_symbol_i  (write_symbol_i),
    .head_move_i     (head_move_i),
    .goto_state_i    (goto_state_i),
    .cell_address_i  (cell_address_i),
    .cell_symbol_i   (cell_symbol_i),
    .machine_state_o (machine_state_o),
    .head_position_o (head_position_o),
    .read_symbol_o   (read_symbol_o),
    .run_status_o    (run_status_o)
  );

endmodule

`default_nettype wire

// File: tb/turing_machine_stepper_core_tb.sv
// Testbench for turing_machine_stepper_core: sends command items, predicts every
// result with a built-in machine model and compares each result field by field.
// Depends on tms_pkg and the stepper core RTL.
`timescale 1ns / 1ps

module turing_machine_stepper_core_tb;
  import tms_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [1:0] MOVE_STAY      = 2'd0;
  localparam logic [1:0] MOVE_SPARE     = 2'd3;
  localparam int PROGRAM_ITEMS = 1900;
  localparam int MAX_REPORTS   = 100;

  typedef struct {
    logic [2:0] op;
    logic [6:0] slot;
    logic [7:0] m_state;
    logic [7:0] m_sym;
    logic [7:0] w_sym;
    logic [1:0] move;
    logic [7:0] next_state;
    logic [9:0] addr;
    logic [7:0] cell_sym;
  } tm_item_t;

  typedef struct {
    logic [7:0] state;
    logic [9:0] head;
    logic [7:0] sym;
    logic [1:0] status;
  } tm_snapshot_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       start          = 1'b0;
  logic       busy;
  logic       done_o;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i    = '0;
  logic [7:0] cfg_data_i     = '0;
  logic [2:0] opcode_i       = '0;
  logic [6:0] rule_index_i   = '0;
  logic [7:0] match_state_i  = '0;
  logic [7:0] match_symbol_i = '0;
  logic [7:0] write_symbol_i = '0;
  logic [1:0] head_move_i    = '0;
  logic [7:0] goto_state_i   = '0;
  logic [9:0] cell_address_i = '0;
  logic [7:0] cell_symbol_i  = '0;
  logic [7:0] machine_state_o;
  logic [9:0] head_position_o;
  logic [7:0] read_symbol_o;
  logic [1:0] run_status_o;

  logic [7:0]            tape_img [TAPE_DEPTH];
  rule_t                 rule_img [RULE_DEPTH];
  bit                    rule_loaded [RULE_DEPTH];
  logic [STATE_BITS-1:0] tm_state;
  logic [9:0]            tm_head;
  logic [1:0]            tm_status;
  logic [7:0]            halt_reg;
  logic [7:0]            start_reg;
  logic [7:0]            count_reg;

  tm_snapshot_t snapshot_q [$];
  tm_snapshot_t seen_want;
  int           mismatch_count = 0;
  int           program_items  = 0;
  bit           no_gaps        = 1'b0;

  turing_machine_stepper_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .done_o         (done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .rule_index_i   (rule_index_i),
    .match_state_i  (match_state_i),
    .match_symbol_i (match_symbol_i),
    .write_symbol_i (write_symbol_i),
    .head_move_i    (head_move_i),
    .goto_state_i   (goto_state_i),
    .cell_address_i (cell_address_i),
    .cell_symbol_i  (cell_symbol_i),
    .machine_state_o(machine_state_o),
    .head_position_o(head_position_o),
    .read_symbol_o  (read_symbol_o),
    .run_status_o   (run_status_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("tb: mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
    end
  endtask

  task automatic advance_machine(input tm_item_t it);
    tm_snapshot_t snap;
    rule_t        hit_rule;
    bit           hit;
    int           lim;
    logic [7:0]   sym;
    case (it.op)
      OP_LOAD: begin
        rule_img[it.slot].m_state = it.m_state;
        rule_img[it.slot].m_sym   = it.m_sym;
        rule_img[it.slot].w_sym   = it.w_sym;
        rule_img[it.slot].move    = it.move;
        rule_img[it.slot].next    = it.next_state;
        rule_loaded[it.slot]      = 1'b1;
      end
      OP_WRITE: tape_img[it.addr] = it.cell_sym;
      OP_STEP: begin
        if (tm_status == RUN_ACTIVE) begin
          if (tm_state == halt_reg) begin
            tm_status = RUN_HALTED;
          end else begin
            lim = (32'(count_reg) > RULE_DEPTH) ? RULE_DEPTH : 32'(count_reg);
            sym = tape_img[tm_head];
            hit = 1'b0;
            for (int i = 0; i < lim && !hit; i++) begin
              if (rule_img[i].m_state == tm_state && rule_img[i].m_sym == sym) begin
                hit      = 1'b1;
                hit_rule = rule_img[i];
              end
            end
            if (!hit) begin
              tm_status = RUN_NO_RULE;
            end else if ((hit_rule.move == MOVE_RIGHT && tm_head == 10'(TAPE_DEPTH - 1)) ||
                         (hit_rule.move == MOVE_LEFT && tm_head == '0)) begin
              tm_status = RUN_OFF_TAPE;
            end else begin
              tape_img[tm_head] = hit_rule.w_sym;
              if (hit_rule.move == MOVE_RIGHT) tm_head = tm_head + 10'd1;
              else if (hit_rule.move == MOVE_LEFT) tm_head = tm_head - 10'd1;
              tm_state = hit_rule.next;
              if (tm_state == halt_reg) tm_status = RUN_HALTED;
            end
          end
        end
      end
      OP_RESTART: begin
        tm_state  = start_reg;
        tm_head   = 10'd1;
        tm_status = RUN_ACTIVE;
      end
      default: ;
    endcase
    snap.state  = tm_state;
    snap.head   = tm_head;
    snap.sym    = (it.op == OP_READ) ? tape_img[it.addr] : tape_img[tm_head];
    snap.status = tm_status;
    snapshot_q.push_back(snap);
  endtask

  function automatic tm_item_t random_item(input logic [2:0] op);
    tm_item_t it;
    it.op         = op;
    it.slot       = 7'($urandom);
    it.m_state    = 8'($urandom);
    it.m_sym      = 8'($urandom);
    it.w_sym      = 8'($urandom);
    it.move       = 2'($urandom);
    it.next_state = 8'($urandom);
    it.addr       = 10'($urandom);
    it.cell_sym   = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input tm_item_t it);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 4));
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy !== 1'b0);
      end
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= it.op;
    rule_index_i   <= it.slot;
    match_state_i  <= it.m_state;
    match_symbol_i <= it.m_sym;
    write_symbol_i <= it.w_sym;
    head_move_i    <= it.move;
    goto_state_i   <= it.next_state;
    cell_address_i <= it.addr;
    cell_symbol_i  <= it.cell_sym;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (it.op <= OP_RESTART) program_items++;
    advance_machine(it);
  endtask

  task automatic send_op(input logic [2:0] op);
    send_item(random_item(op));
  endtask

  task automatic send_load(input int slot, input logic [7:0] ms, input logic [7:0] msym,
                           input logic [7:0] wsym, input logic [1:0] mv,
                           input logic [7:0] nx);
    tm_item_t it;
    it            = random_item(OP_LOAD);
    it.slot       = 7'(slot);
    it.m_state    = ms;
    it.m_sym      = msym;
    it.w_sym      = wsym;
    it.move       = mv;
    it.next_state = nx;
    send_item(it);
  endtask

  task automatic send_read(input logic [9:0] addr);
    tm_item_t it;
    it      = random_item(OP_READ);
    it.addr = addr;
    send_item(it);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (snapshot_q.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_HALT_CODE:  halt_reg  = val;
      CFG_START_CODE: start_reg = val;
      CFG_RULE_COUNT: count_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (snapshot_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        seen_want = snapshot_q.pop_front();
        if (machine_state_o !== seen_want.state)
          report_mismatch("machine_state", 32'(machine_state_o), 32'(seen_want.state));
        if (head_position_o !== seen_want.head)
          report_mismatch("head_position", 32'(head_position_o), 32'(seen_want.head));
        if (read_symbol_o !== seen_want.sym)
          report_mismatch("read_symbol", 32'(read_symbol_o), 32'(seen_want.sym));
        if (run_status_o !== seen_want.status)
          report_mismatch("run_status", 32'(run_status_o), 32'(seen_want.status));
      end
    end
  end

  task automatic test_after_reset();
    settle();
    send_read(10'd0);
    send_read(10'd1);
    send_read(10'(TAPE_DEPTH - 1));
    send_op(OP_SPARE_FIRST);
    send_op(OP_SPARE_LAST);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_op(OP_RESTART);
  endtask

  task automatic test_right_edge();
    send_load(0, START_RESET, BLANK_SYMBOL, BLANK_SYMBOL, MOVE_RIGHT, START_RESET);
    settle();
    write_reg(CFG_RULE_COUNT, 8'd1);
    while (tm_status == RUN_ACTIVE) begin
      no_gaps = (tm_head > TAPE_DEPTH / 2);
      send_op(OP_STEP);
    end
    no_gaps = 1'b0;
    send_op(OP_STEP);
    send_read(10'(TAPE_DEPTH - 1));
    send_op(OP_RESTART);
  endtask

  task automatic test_left_edge();
    send_load(0, START_RESET, BLANK_SYMBOL, BLANK_SYMBOL, MOVE_LEFT, START_RESET);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_op(OP_RESTART);
    send_load(0, START_RESET, BLANK_SYMBOL, 8'hFF, MOVE_SPARE, 8'd1);
    send_load(1, 8'd1, 8'hFF, 8'h00, MOVE_RIGHT, HALT_RESET);
    settle();
    write_reg(CFG_RULE_COUNT, 8'd2);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_read(10'd1);
    send_op(OP_RESTART);
  endtask

  task automatic test_halt_codes();
    settle();
    write_reg(CFG_HALT_CODE, 8'd0);
    write_reg(CFG_START_CODE, 8'd0);
    send_op(OP_RESTART);
    send_op(OP_STEP);
    send_op(OP_STEP);
    settle();
    write_reg(CFG_HALT_CODE, 8'd255);
    write_reg(CFG_START_CODE, 8'd255);
    send_op(OP_RESTART);
    send_op(OP_STEP);
  endtask

  task automatic test_rule_search_depth();
    logic [7:0] under_head;
    for (int i = 0; i < RULE_DEPTH - 1; i++) begin
      send_load(i, 8'hA5, 8'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
    end
    under_head = tape_img[1];
    send_load(RULE_DEPTH - 1, 8'h5A, under_head, under_head, MOVE_STAY, 8'h5A);
    settle();
    write_reg(CFG_START_CODE, 8'h5A);
    write_reg(CFG_HALT_CODE, HALT_RESET);
    write_reg(CFG_RULE_COUNT, 8'd255);
    send_op(OP_RESTART);
    send_op(OP_STEP);
    send_op(OP_STEP);
    settle();
    write_reg(CFG_RULE_COUNT, 8'(RULE_DEPTH));
    send_op(OP_STEP);
    settle();
    write_reg(CFG_RULE_COUNT, 8'(RULE_DEPTH - 1));
    send_op(OP_STEP);
    send_op(OP_RESTART);
  endtask

  task automatic test_random_programs();
    tm_item_t   it;
    logic [7:0] states [4];
    logic [7:0] syms [4];
    logic [7:0] halt_val;
    logic [7:0] count_val;
    int         n;
    int         steps;
    int         prefix;
    int         quota;
    bit         deep;
    quota = PROGRAM_ITEMS;
    while (program_items < quota) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      deep    = ($urandom_range(0, 15) == 0);
      n       = deep ? RULE_DEPTH : int'($urandom_range(1, 12));
      foreach (states[k]) states[k] = 8'($urandom);
      foreach (syms[k]) syms[k] = 8'($urandom);
      if ($urandom_range(0, 1) == 1) syms[0] = BLANK_SYMBOL;
      halt_val = ($urandom_range(0, 2) == 0) ? states[3] : 8'($urandom);
      for (int i = 0; i < n; i++) begin
        it            = random_item(OP_LOAD);
        it.slot       = 7'(i);
        it.m_state    = (deep && i < 96) ? 8'($urandom) : states[$urandom_range(0, 3)];
        it.m_sym      = syms[$urandom_range(0, 3)];
        it.w_sym      = syms[$urandom_range(0, 3)];
        it.next_state = ($urandom_range(0, 7) == 0) ? halt_val : states[$urandom_range(0, 3)];
        send_item(it);
      end
      repeat ($urandom_range(2, 8)) begin
        it          = random_item(OP_WRITE);
        it.addr     = 10'($urandom_range(0, 15));
        it.cell_sym = syms[$urandom_range(0, 3)];
        send_item(it);
      end
      settle();
      prefix = 0;
      while (prefix < RULE_DEPTH && rule_loaded[prefix]) prefix++;
      count_val = 8'(n);
      if (deep && $urandom_range(0, 1) == 1) count_val = 8'd255;
      if ($urandom_range(0, 7) == 0) begin
        count_val = (prefix == RULE_DEPTH) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, prefix));
      end
      write_reg(CFG_HALT_CODE, halt_val);
      write_reg(CFG_START_CODE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : states[0]);
      write_reg(CFG_RULE_COUNT, count_val);
      send_op(OP_RESTART);
      steps = int'($urandom_range(10, 60));
      while (steps > 0) begin
        if ($urandom_range(0, 7) == 0) begin
          send_op(3'($urandom_range(0, OP_SPARE_LAST)));
        end else begin
          send_op(OP_STEP);
          steps--;
          if (tm_status != RUN_ACTIVE) begin
            if ($urandom_range(0, 1) == 1) send_op(OP_STEP);
            if ($urandom_range(0, 2) == 0) send_op(OP_RESTART);
            else steps = 0;
          end
        end
      end
      send_read(10'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (tape_img[i]) tape_img[i] = BLANK_SYMBOL;
    foreach (rule_img[i]) rule_img[i] = '0;
    foreach (rule_loaded[i]) rule_loaded[i] = 1'b0;
    halt_reg  = HALT_RESET;
    start_reg = START_RESET;
    count_reg = COUNT_RESET;
    tm_state  = START_RESET;
    tm_head   = 10'd1;
    tm_status = RUN_ACTIVE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_right_edge();
    test_left_edge();
    test_halt_codes();
    test_rule_search_depth();
    test_random_programs();
    settle();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tms_pkg.sv
rtl/tms_ram.sv
rtl/tms_datapath.sv
rtl/tms_ctrl.sv
rtl/turing_machine_stepper_core.sv
tb/turing_machine_stepper_core_tb.sv
